>>> rtl/core/spb_pkg.sv
// Shared types and constants of the sorted packet buffer.
// No dependencies; every other file of the block imports this package.
package spb_pkg;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SRC_W = $clog2(2 * CAPACITY);

  // Field widths of the beats on the ports
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int SEQ_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 16;
  localparam int DEST_W   = 8;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT       = 3'd0,
    CMD_LOOKUP       = 3'd1,
    CMD_PEEK         = 3'd2,
    CMD_POP          = 3'd3,
    CMD_REMOVE_BELOW = 3'd4,
    CMD_CLEAR        = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_MISS = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]       seq;
    logic [HANDLE_BITS-1:0] handle;
    logic [LEN_W-1:0]       length;
    logic [DEST_W-1:0]      dest;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the command beat and the slot compares
    logic execute;  // update the chain and load the result register
  } dp_cmd_t;

endpackage

>>> rtl/core/spb_ctrl.sv
// Controller of the sorted packet buffer: command sequencing and output handshake.
// Depends on spb_pkg.
module spb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output spb_pkg::dp_cmd_t dp_cmd
);
  import spb_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        dp_cmd.capture = in_valid;
      end
      S_EXEC: begin
        dp_cmd.execute = !out_valid || out_ready;
      end
      default: ;
    endcase
    out_valid_next = out_valid;
    if (dp_cmd.execute) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  a_capture_to_exec : assert property (@(posedge clk) disable iff (rst)
    dp_cmd.capture |=> (state == S_EXEC) && !in_ready)
    else $error("captured command did not move to execute");

  a_exec_loads_result : assert property (@(posedge clk) disable iff (rst)
    dp_cmd.execute |=> out_valid && (state == S_IDLE))
    else $error("execute did not present a result");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && out_valid && !out_ready |-> !dp_cmd.execute)
    else $error("result register overwritten while held");

  a_one_command_in_flight : assert property (@(posedge clk) disable iff (rst)
    dp_cmd.capture |-> !dp_cmd.execute)
    else $error("capture and execute in the same cycle");

endmodule

>>> rtl/core/spb_datapath.sv
// Datapath of the sorted packet buffer: sorted slot chain, compares and result register.
// Depends on spb_pkg.
module spb_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  spb_pkg::dp_cmd_t                 dp_cmd,
  input  logic [spb_pkg::CMD_W-1:0]        in_cmd,
  input  logic [spb_pkg::SEQ_W-1:0]        in_seq,
  input  logic [spb_pkg::HANDLE_W-1:0]     in_handle,
  input  logic [spb_pkg::LEN_W-1:0]        in_length,
  input  logic [spb_pkg::DEST_W-1:0]       in_dest,
  output logic [spb_pkg::STATUS_W-1:0]     status,
  output logic [spb_pkg::SEQ_W-1:0]        found_seq,
  output logic [spb_pkg::HANDLE_W-1:0]     found_handle,
  output logic [spb_pkg::LEN_W-1:0]        found_length,
  output logic [spb_pkg::DEST_W-1:0]       found_dest,
  output logic [spb_pkg::COUNT_W-1:0]      removed_count,
  output logic [spb_pkg::COUNT_W-1:0]      occupancy
);
  import spb_pkg::*;

  // Slot chain; valid slots always form the prefix 0..count-1 in ascending order
  entry_t              ent [CAPACITY];
  logic [CAPACITY-1:0] ent_valid;
  logic [CNT_W-1:0]    count;

  // Latched command
  cmd_t                cmd_r;
  entry_t              new_r;
  logic [CAPACITY-1:0] lt_r;
  logic [CAPACITY-1:0] eq_r;

  logic [CAPACITY-1:0] lt_in;
  logic [CAPACITY-1:0] eq_in;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_in[i] = ent_valid[i] && (ent[i].seq < in_seq);
      eq_in[i] = ent_valid[i] && (ent[i].seq == in_seq);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r         <= cmd_t'(in_cmd);
      new_r.seq     <= in_seq;
      new_r.handle  <= HANDLE_BITS'(in_handle);
      new_r.length  <= in_length;
      new_r.dest    <= in_dest;
      lt_r          <= lt_in;
      eq_r          <= eq_in;
    end
  end

  // Position of the first slot not below the key (lt_r is a thermometer)
  logic [CAPACITY:0] lt_ext;
  logic [CNT_W-1:0]  pos;

  assign lt_ext = {1'b0, lt_r};

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) pos = pos | CNT_W'(i + 1);
    end
  end

  // Insert view: slots below the key hold, the key lands at pos, the rest move up
  entry_t              ent_up  [CAPACITY];
  logic [CAPACITY-1:0] valid_up;
  logic [CAPACITY-1:0] lt_lo;
  entry_t              ent_ins [CAPACITY];
  logic [CAPACITY-1:0] valid_ins;

  assign lt_lo = {lt_r[CAPACITY-2:0], 1'b1};
  assign valid_up = {ent_valid[CAPACITY-2:0], 1'b0};

  always_comb begin
    ent_up[0] = '0;
    for (int i = 1; i < CAPACITY; i++) ent_up[i] = ent[i-1];
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_r[i]) begin
        ent_ins[i]   = ent[i];
        valid_ins[i] = ent_valid[i];
      end else if (lt_lo[i]) begin
        ent_ins[i]   = new_r;
        valid_ins[i] = 1'b1;
      end else begin
        ent_ins[i]   = ent_up[i];
        valid_ins[i] = valid_up[i];
      end
    end
  end

  // Drop view: slot i takes slot i + dn_amt, slots past the end go invalid
  logic [CNT_W-1:0]    dn_amt;
  entry_t              ent_dn  [CAPACITY];
  logic [CAPACITY-1:0] valid_dn;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_dn[i]   = ent[i];
      valid_dn[i] = 1'b0;
      for (int j = i; j < CAPACITY; j++) begin
        if (SRC_W'(j) == SRC_W'(i) + SRC_W'(dn_amt)) begin
          ent_dn[i]   = ent[j];
          valid_dn[i] = ent_valid[j];
        end
      end
    end
  end

  // Command decode
  logic                dup;
  logic                full;
  logic                do_ins;
  logic                do_dn;
  logic                do_clr;
  logic [CAPACITY-1:0] sel;
  status_t             sts_next;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    removed_next;
  entry_t              found;

  assign dup  = |eq_r;
  assign full = (count == CNT_W'(CAPACITY));

  always_comb begin
    do_ins       = 1'b0;
    do_dn        = 1'b0;
    do_clr       = 1'b0;
    dn_amt       = '0;
    sel          = '0;
    sts_next     = STS_OK;
    count_next   = count;
    removed_next = '0;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (dup) begin
          sts_next = STS_DUP;
        end else if (full) begin
          sts_next = STS_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_LOOKUP: begin
        sel      = eq_r;
        sts_next = dup ? STS_OK : STS_MISS;
      end
      CMD_PEEK: begin
        sel[0]   = ent_valid[0];
        sts_next = ent_valid[0] ? STS_OK : STS_MISS;
      end
      CMD_POP: begin
        sel[0]   = ent_valid[0];
        sts_next = ent_valid[0] ? STS_OK : STS_MISS;
        if (ent_valid[0]) begin
          do_dn      = 1'b1;
          dn_amt     = CNT_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      CMD_REMOVE_BELOW: begin
        do_dn        = 1'b1;
        dn_amt       = pos;
        count_next   = count - pos;
        removed_next = pos;
      end
      CMD_CLEAR: begin
        do_clr       = 1'b1;
        count_next   = '0;
        removed_next = count;
      end
      default: ;
    endcase
  end

  always_comb begin
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) found = found | ent[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      count     <= '0;
    end else if (dp_cmd.execute) begin
      count <= count_next;
      if (do_ins) ent_valid <= valid_ins;
      else if (do_dn) ent_valid <= valid_dn;
      else if (do_clr) ent_valid <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins) ent[i] <= ent_ins[i];
        else if (do_dn) ent[i] <= ent_dn[i];
      end
      status        <= sts_next;
      found_seq     <= found.seq;
      found_handle  <= HANDLE_W'(found.handle);
      found_length  <= found.length;
      found_dest    <= found.dest;
      removed_count <= COUNT_W'(removed_next);
      occupancy     <= COUNT_W'(count_next);
    end
  end

endmodule

>>> rtl/core/sorted_packet_buffer.sv
// Top level of the sorted packet buffer: stream ports, beat packing, controller and datapath.
// Depends on spb_pkg, spb_ctrl and spb_datapath.
//
//  channel   direction  payload
//  s_axis    in         command beat: tuser = cmd, tdata = seq, handle, length, dest
//  m_axis    out        result beat:  tuser = status, tdata = found entry, counts
//
// Each command runs in two steps: the first takes the beat and registers the compare of the
// key against every slot, the second shifts the slot chain and loads the result register.
// A new command beat is taken while the previous result still waits on m_axis.
// If that result is still held when the next command is ready to execute, the
// command waits in the chain stage until the result beat is taken.
// Reset empties the buffer at once; there is no clearing pass.
module sorted_packet_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // seq[31:0], handle[47:32], length[63:48], dest[71:64]
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // found_seq[31:0], found_handle[47:32],
                                      // found_length[63:48], found_dest[71:64],
                                      // removed_count[76:72], occupancy[81:77], zero above
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import spb_pkg::*;

  dp_cmd_t             dp_cmd;
  logic [STATUS_W-1:0] status;
  logic [SEQ_W-1:0]    found_seq;
  logic [HANDLE_W-1:0] found_handle;
  logic [LEN_W-1:0]    found_length;
  logic [DEST_W-1:0]   found_dest;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  occupancy;

  // Sequence the command: take beat, execute, hold result until taken
  spb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dp_cmd    (dp_cmd)
  );

  // Unpack the command beat straight into the datapath
  spb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .in_cmd        (s_axis_tuser),
    .in_seq        (s_axis_tdata[31:0]),
    .in_handle     (s_axis_tdata[47:32]),
    .in_length     (s_axis_tdata[63:48]),
    .in_dest       (s_axis_tdata[71:64]),
    .status        (status),
    .found_seq     (found_seq),
    .found_handle  (found_handle),
    .found_length  (found_length),
    .found_dest    (found_dest),
    .removed_count (removed_count),
    .occupancy     (occupancy)
  );

  // Pack the result beat; pad tdata to whole bytes with zeros
  assign m_axis_tuser = status;
  assign m_axis_tdata = {6'b0, occupancy, removed_count, found_dest, found_length,
                         found_handle, found_seq};

endmodule
